// ===== rtl/core/plp_pkg.sv =====
`timescale 1ns / 1ps

package plp_pkg;

	// Field widths fixed by the stream format
	localparam int CHAR_W   = 8;
	localparam int VALUE_W  = 28;
	localparam int MAG_W    = 27;
	localparam int INDEX_W  = 5;
	localparam int CMDLEN_W = 6;
	localparam int REGIDX_W = 3;
	localparam int OUT_W    = 40;

	localparam logic [MAG_W-1:0]   VALUE_CAP = '1;
	localparam logic [INDEX_W-1:0] COUNT_CAP = '1;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// Register indexes
	localparam logic [REGIDX_W-1:0] REG_COMMAND_LENGTH = 3'd0;
	localparam logic [REGIDX_W-1:0] REG_EXPECTED_COUNT = 3'd1;
	localparam logic [REGIDX_W-1:0] REG_REQUIRE_EQUALS = 3'd2;
	localparam logic [REGIDX_W-1:0] REG_SEPARATOR_ONE  = 3'd3;
	localparam logic [REGIDX_W-1:0] REG_SEPARATOR_TWO  = 3'd4;
	localparam logic [REGIDX_W-1:0] REG_EQUALS_CHAR    = 3'd5;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_EQUALS  = 2'd1,
		ST_BAD_LENGTH = 2'd2,
		ST_COUNT      = 2'd3
	} status_t;

	typedef struct packed {
		logic [CMDLEN_W-1:0] command_length;
		logic [INDEX_W-1:0]  expected_count;
		logic                require_equals;
		logic [CHAR_W-1:0]   separator_one;
		logic [CHAR_W-1:0]   separator_two;
		logic [CHAR_W-1:0]   equals_char;
	} cfg_t;

	typedef struct packed {
		logic               has_result;
		logic [VALUE_W-1:0] param_value;
		logic [INDEX_W-1:0] param_index;
		logic               param_valid;
		status_t            status;
		logic               done_res;
	} result_t;

endpackage

// ===== rtl/core/parameter_list_parser.sv =====
`timescale 1ns / 1ps

// Parameter list parser. Feed one command line as a stream of characters,
// one per transaction (tdata = character code, tuser = 1 on the first
// character of a line). The parser skips command_length command characters,
// optionally checks for equals_char, then splits the rest at either separator
// or at the NUL terminator into signed decimal tokens. Each parameter comes out
// as one output transaction with its value and index; the transaction that ends
// the line has tlast set and carries the final status (0 ok, 1 missing equals,
// 2 bad token length, 3 count mismatch), possibly together with the last
// parameter. Characters after the end of a line are dropped until the next
// line start. Throughput is one character per clock: a character is held in
// the input register, the parse step is a single combinational pass between
// that register and the output register, and a new character is taken every
// cycle unless the output register is full and stalled. Configuration
// registers are written through cfg_we/cfg_index/cfg_data while the stream is
// idle; reset values are 0, 0, 1, ',', ' ', '='.
module parameter_list_parser #(
	parameter int MAX_LINE  = 32,
	parameter int MAX_TOKEN = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input characters
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] char_code
	input  logic                           s_axis_tuser,  // line_start
	// parsed parameters
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [27:0] param_value, [32:28] param_index, [33] param_valid,
	// [35:34] status, [39:36] zero
	output logic [plp_pkg::OUT_W-1:0]      m_axis_tdata,
	output logic                           m_axis_tlast,  // done_res
	// configuration writes
	input  logic                           cfg_we,
	input  logic [plp_pkg::REGIDX_W-1:0]   cfg_index,
	input  logic [plp_pkg::CHAR_W-1:0]     cfg_data
);

	plp_pkg::cfg_t    cfg_q;
	plp_pkg::result_t res;

	logic                         in_valid_s1;
	logic [plp_pkg::CHAR_W-1:0]   char_s1;
	logic                         line_start_s1;
	logic                         out_free, step;

	logic                         out_valid_q;
	logic [plp_pkg::VALUE_W-1:0]  value_q;
	logic [plp_pkg::INDEX_W-1:0]  index_q;
	logic                         pvalid_q, done_q;
	plp_pkg::status_t             status_q;

	// Configuration registers: written directly, no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_length <= '0;
			cfg_q.expected_count <= '0;
			cfg_q.require_equals <= 1'b1;
			cfg_q.separator_one  <= 8'd44;
			cfg_q.separator_two  <= 8'd32;
			cfg_q.equals_char    <= 8'd61;
		end else if (cfg_we) begin
			unique case (cfg_index)
				plp_pkg::REG_COMMAND_LENGTH:
					cfg_q.command_length <= cfg_data[plp_pkg::CMDLEN_W-1:0];
				plp_pkg::REG_EXPECTED_COUNT:
					cfg_q.expected_count <= cfg_data[plp_pkg::INDEX_W-1:0];
				plp_pkg::REG_REQUIRE_EQUALS: cfg_q.require_equals <= cfg_data[0];
				plp_pkg::REG_SEPARATOR_ONE:  cfg_q.separator_one  <= cfg_data;
				plp_pkg::REG_SEPARATOR_TWO:  cfg_q.separator_two  <= cfg_data;
				plp_pkg::REG_EQUALS_CHAR:    cfg_q.equals_char    <= cfg_data;
				default: ;  // writes to unused indexes are ignored
			endcase
		end
	end

	// The output register may take a new result when empty or being drained.
	assign out_free      = !out_valid_q || m_axis_tready;
	// Advance the held character through the parse step once its result,
	// if any, has somewhere to go.
	assign step          = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1       <= s_axis_tdata;
			line_start_s1 <= s_axis_tuser;
		end
	end

	// Parse state and the single-pass step logic
	plp_core #(
		.MAX_LINE  (MAX_LINE),
		.MAX_TOKEN (MAX_TOKEN)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.char_code  (char_s1),
		.line_start (line_start_s1),
		.cfg        (cfg_q),
		.res        (res)
	);

	// Output register: hold a result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.has_result) begin
			value_q  <= res.param_value;
			index_q  <= res.param_index;
			pvalid_q <= res.param_valid;
			status_q <= res.status;
			done_q   <= res.done_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, status_q, pvalid_q, index_q, value_q};
	assign m_axis_tlast  = done_q;

endmodule

// ===== rtl/core/plp_core.sv =====
`timescale 1ns / 1ps

module plp_core #(
	parameter int MAX_LINE  = 32,
	parameter int MAX_TOKEN = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [plp_pkg::CHAR_W-1:0]    char_code,
	input  logic                          line_start,
	input  plp_pkg::cfg_t                 cfg,
	output plp_pkg::result_t              res
);

	localparam int POS_W  = $clog2(MAX_LINE + 1);
	localparam int TLEN_W = $clog2(MAX_TOKEN + 2);
	localparam logic [POS_W-1:0]  LINE_LIMIT  = POS_W'(MAX_LINE);
	localparam logic [TLEN_W-1:0] TOKEN_LIMIT = TLEN_W'(MAX_TOKEN);

	logic                          finished_q, in_params_q, negative_q, digits_open_q;
	logic [plp_pkg::CMDLEN_W-1:0]  prefix_q;
	logic [POS_W-1:0]              position_q;
	logic [TLEN_W-1:0]             tlen_q;
	logic [plp_pkg::MAG_W-1:0]     tvalue_q;
	logic [plp_pkg::INDEX_W-1:0]   count_q;

	logic                          finished_d, in_params_d, negative_d, digits_open_d;
	logic [plp_pkg::CMDLEN_W-1:0]  prefix_d;
	logic [POS_W-1:0]              position_d;
	logic [TLEN_W-1:0]             tlen_d;
	logic [plp_pkg::MAG_W-1:0]     tvalue_d;
	logic [plp_pkg::INDEX_W-1:0]   count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q    <= 1'b1;
			in_params_q   <= 1'b0;
			negative_q    <= 1'b0;
			digits_open_q <= 1'b1;
			prefix_q      <= '0;
			position_q    <= '0;
			tlen_q        <= '0;
			tvalue_q      <= '0;
			count_q       <= '0;
		end else if (step) begin
			finished_q    <= finished_d;
			in_params_q   <= in_params_d;
			negative_q    <= negative_d;
			digits_open_q <= digits_open_d;
			prefix_q      <= prefix_d;
			position_q    <= position_d;
			tlen_q        <= tlen_d;
			tvalue_q      <= tvalue_d;
			count_q       <= count_d;
		end
	end

	always_comb begin
		logic                        run_params, len_ok, is_sep, is_digit;
		logic                        emit, emit_valid, emit_done;
		plp_pkg::status_t            emit_status;
		logic [plp_pkg::CHAR_W-1:0]  c;
		logic [plp_pkg::MAG_W+3:0]   nv;
		logic [plp_pkg::VALUE_W-1:0] mag;

		finished_d    = finished_q;
		in_params_d   = in_params_q;
		negative_d    = negative_q;
		digits_open_d = digits_open_q;
		prefix_d      = prefix_q;
		position_d    = position_q;
		tlen_d        = tlen_q;
		tvalue_d      = tvalue_q;
		count_d       = count_q;
		run_params    = 1'b0;
		emit          = 1'b0;
		emit_valid    = 1'b0;
		emit_done     = 1'b0;
		emit_status   = plp_pkg::ST_OK;
		c             = char_code;
		nv            = '0;

		if (line_start) begin
			finished_d    = 1'b0;
			in_params_d   = 1'b0;
			negative_d    = 1'b0;
			digits_open_d = 1'b1;
			prefix_d      = '0;
			position_d    = '0;
			tlen_d        = '0;
			tvalue_d      = '0;
			count_d       = '0;
		end

		if (!finished_d) begin
			if (in_params_d) begin
				run_params = 1'b1;
			end else if (prefix_d < cfg.command_length) begin
				if (c == plp_pkg::CH_NUL) begin
					emit        = 1'b1;
					emit_done   = 1'b1;
					emit_status = cfg.require_equals ? plp_pkg::ST_NO_EQUALS
					                                 : plp_pkg::ST_BAD_LENGTH;
				end else begin
					prefix_d = prefix_d + 1'b1;
				end
			end else if (cfg.require_equals) begin
				if (c != cfg.equals_char) begin
					emit        = 1'b1;
					emit_done   = 1'b1;
					emit_status = plp_pkg::ST_NO_EQUALS;
				end else begin
					in_params_d = 1'b1;
				end
			end else begin
				in_params_d = 1'b1;
				run_params  = 1'b1;
			end
		end

		len_ok   = (tlen_d != '0) && (tlen_d <= TOKEN_LIMIT);
		is_sep   = 1'b0;
		is_digit = 1'b0;

		if (run_params) begin
			// Past the line limit the character counts as the terminator
			if (position_d >= LINE_LIMIT) begin
				c = plp_pkg::CH_NUL;
			end else begin
				position_d = position_d + 1'b1;
			end
			is_sep   = (c == cfg.separator_one) || (c == cfg.separator_two);
			is_digit = (c >= plp_pkg::CH_ZERO) && (c <= plp_pkg::CH_NINE);

			if (c == plp_pkg::CH_NUL) begin
				emit      = 1'b1;
				emit_done = 1'b1;
				if (!len_ok) begin
					emit_status = plp_pkg::ST_BAD_LENGTH;
				end else if (cfg.expected_count == '0) begin
					emit_valid = 1'b1;
				end else if (count_d < cfg.expected_count) begin
					emit_valid  = 1'b1;
					emit_status = ((count_d + 1'b1) != cfg.expected_count)
					              ? plp_pkg::ST_COUNT : plp_pkg::ST_OK;
				end else begin
					emit_status = plp_pkg::ST_COUNT;
				end
			end else if (is_sep) begin
				emit = 1'b1;
				if (!len_ok) begin
					emit_done   = 1'b1;
					emit_status = plp_pkg::ST_BAD_LENGTH;
				end else if ((cfg.expected_count != '0) && (count_d >= cfg.expected_count)) begin
					emit_done   = 1'b1;
					emit_status = plp_pkg::ST_COUNT;
				end else begin
					emit_valid = 1'b1;
				end
			end else begin
				if ((tlen_d == '0) && ((c == plp_pkg::CH_MINUS) || (c == plp_pkg::CH_PLUS))) begin
					negative_d = (c == plp_pkg::CH_MINUS);
				end else if (digits_open_d && is_digit) begin
					nv = {tvalue_d, 3'b000} + {2'b00, tvalue_d, 1'b0}
					   + (plp_pkg::MAG_W+4)'(c - plp_pkg::CH_ZERO);
					tvalue_d = (nv[plp_pkg::MAG_W+3:plp_pkg::MAG_W] != '0)
					           ? plp_pkg::VALUE_CAP : nv[plp_pkg::MAG_W-1:0];
				end else begin
					digits_open_d = 1'b0;
				end
				if (tlen_d <= TOKEN_LIMIT) begin
					tlen_d = tlen_d + 1'b1;
				end
			end
		end

		// Result fields come from the token as it stood before this character
		mag = {1'b0, tvalue_d};
		res.has_result  = emit;
		res.param_valid = emit_valid;
		res.param_value = emit_valid ? (negative_d ? plp_pkg::VALUE_W'(-mag) : mag) : '0;
		res.param_index = emit_valid ? count_d : '0;
		res.status      = emit_status;
		res.done_res    = emit_done;

		if (emit_done) begin
			finished_d = 1'b1;
		end
		if (emit && !emit_done) begin
			if (count_d < plp_pkg::COUNT_CAP) begin
				count_d = count_d + 1'b1;
			end
			tlen_d        = '0;
			tvalue_d      = '0;
			negative_d    = 1'b0;
			digits_open_d = 1'b1;
		end
	end

endmodule

// ===== rtl/core/plp_checker.sv =====
`timescale 1ns / 1ps

module plp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [plp_pkg::OUT_W-1:0]       m_axis_tdata,
	input logic                            m_axis_tlast
);

	// A result held back by the sink stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transaction dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	// A mid-line result is always a clean parameter.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[33] && (m_axis_tdata[35:34] == 2'b00))
		else $error("mid-line result without parameter or with status");

	// Without a parameter, value and index read zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[33] |-> (m_axis_tdata[32:0] == 33'd0))
		else $error("empty result carries value or index");

endmodule

bind parameter_list_parser plp_checker u_plp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
